// ----- rtl/soa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slab object allocator package
// Shared field widths, codes, defaults and transfer types of the allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_CACHES        = 16;
    localparam int DEF_OBJECTS_PER_CACHE = 64;

    // configuration port
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_OBJECTS_IN_CACHE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIXED_CACHES     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CACHE_LIMIT      = 2'd2;

    localparam int OBJ_CNT_REG_W = 7;
    localparam int FIXED_REG_W   = 5;
    localparam int LIMIT_REG_W   = 5;

    localparam logic [OBJ_CNT_REG_W-1:0] RST_OBJECTS_IN_CACHE = 7'd64;
    localparam logic [FIXED_REG_W-1:0]   RST_FIXED_CACHES     = 5'd1;
    localparam logic [LIMIT_REG_W-1:0]   RST_CACHE_LIMIT      = 5'd0;

    // payload field widths
    localparam int CACHE_FIELD_W = 4;
    localparam int OBJ_FIELD_W   = 6;
    localparam int FLAT_FIELD_W  = 10;
    localparam int STATUS_W      = 2;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic [CACHE_FIELD_W-1:0] free_cache;
        logic [OBJ_FIELD_W-1:0]   free_object;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [CACHE_FIELD_W-1:0] got_cache;
        logic [OBJ_FIELD_W-1:0]   got_object;
        logic [FLAT_FIELD_W-1:0]  flat_index;
    } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/slab_object_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slab object allocator unit
// Bitmap slab allocator: one used map per cache, searched by a sequencer.
// ----------------------------------------------------------------------------
// One request at a time. An allocation walks the caches in index order, one
// cache per cycle through the registered read port of the used-map memory,
// and one shared priority encoder picks the lowest free object of the cache
// in the check slot. The walk covers the effective list length, at most
// MAX_CACHES caches. A hit or a placed cache goes on to S_FLAT, which
// registers the flat index, and then to S_DONE; with no space left the
// scan goes straight to S_DONE. S_DONE loads the output register once it is
// free and returns to S_IDLE. A free reads the map at the transfer edge,
// then takes check and write-back in S_FCHK and the result in S_DONE. The
// input is ready only while the sequencer is idle; the output register holds
// a result until it is taken, and a later request may already run behind
// it. The used maps come out of reset empty through one valid bit per cache,
// so no clearing pass is needed.
module slab_object_allocator_unit #(
    parameter int MAX_CACHES        = soa_pkg::DEF_MAX_CACHES,
    parameter int OBJECTS_PER_CACHE = soa_pkg::DEF_OBJECTS_PER_CACHE
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [soa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [soa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire soa_pkg::req_t                      in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output soa_pkg::rsp_t                           out_data
);
    import soa_pkg::*;

    localparam int CIDX_W = (MAX_CACHES > 1) ? $clog2(MAX_CACHES) : 1;
    localparam int LEN_W  = $clog2(MAX_CACHES + 1);
    localparam int OBJ_W  = (OBJECTS_PER_CACHE > 1) ? $clog2(OBJECTS_PER_CACHE) : 1;
    localparam int OCNT_W = $clog2(OBJECTS_PER_CACHE + 1);
    localparam int PROD_W = OCNT_W + CIDX_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FCHK = 3'd2;
    localparam logic [2:0] S_FLAT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    typedef logic [OBJECTS_PER_CACHE-1:0] word_t;

    // configuration
    logic [OBJ_CNT_REG_W-1:0] objects_in_cache_reg;
    logic [FIXED_REG_W-1:0]   fixed_caches_reg;
    logic [LIMIT_REG_W-1:0]   cache_limit_reg;

    // used-map memory and its per-entry valid bits
    word_t                   used_mem [MAX_CACHES];
    logic [MAX_CACHES-1:0]   mem_vld_reg;
    logic [CIDX_W-1:0]       rd_addr;
    word_t                   rd_data_reg;
    logic                    rd_vld_reg;
    word_t                   rd_word;
    logic                    wr_en;
    logic [CIDX_W-1:0]       wr_addr;
    word_t                   wr_data;

    // sequencer state
    logic [2:0]              state_reg, state_next;
    logic [LEN_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    chk_valid_reg, chk_valid_next;
    logic [CIDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                    have_abs_reg, have_abs_next;
    logic [CIDX_W-1:0]       abs_idx_reg, abs_idx_next;
    logic [LEN_W-1:0]        list_len_reg, list_len_next;
    logic [MAX_CACHES-1:0]   present_reg, present_next;
    logic                    req_type_reg, req_type_next;
    logic [CACHE_FIELD_W-1:0] req_cache_reg, req_cache_next;
    logic [OBJ_FIELD_W-1:0]  req_obj_reg, req_obj_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [CIDX_W-1:0]       res_cache_reg, res_cache_next;
    logic [OBJ_W-1:0]        res_obj_reg, res_obj_next;
    logic [FLAT_FIELD_W-1:0] res_flat_reg, res_flat_next;
    logic                    out_valid_reg, out_valid_next;
    rsp_t                    out_data_reg, out_data_next;

    // effective register values
    logic [OCNT_W-1:0]       eff_obj;
    logic [LEN_W-1:0]        eff_fixed;
    logic [LEN_W-1:0]        eff_limit;
    logic [LEN_W-1:0]        eff_len;
    word_t                   obj_mask;

    // shared search unit
    word_t                   avail;
    logic [OBJ_W-1:0]        low_idx;

    // free path
    logic [CIDX_W-1:0]       fc_idx;
    logic [OBJ_W-1:0]        fo_idx;
    word_t                   freed_word;
    logic [PROD_W-1:0]       flat_sum;

    always_comb
    begin
        if (objects_in_cache_reg == '0)
            eff_obj = OCNT_W'(1);
        else if (32'(objects_in_cache_reg) > OBJECTS_PER_CACHE)
            eff_obj = OCNT_W'(OBJECTS_PER_CACHE);
        else
            eff_obj = OCNT_W'(objects_in_cache_reg);

        if (fixed_caches_reg == '0)
            eff_fixed = LEN_W'(1);
        else if (32'(fixed_caches_reg) > MAX_CACHES)
            eff_fixed = LEN_W'(MAX_CACHES);
        else
            eff_fixed = LEN_W'(fixed_caches_reg);

        if (cache_limit_reg == '0 || 32'(cache_limit_reg) > MAX_CACHES)
            eff_limit = LEN_W'(MAX_CACHES);
        else
            eff_limit = LEN_W'(cache_limit_reg);

        eff_len = (list_len_reg < eff_fixed) ? eff_fixed : list_len_reg;
    end

    always_comb
    begin
        for (int b = 0; b < OBJECTS_PER_CACHE; b++)
            obj_mask[b] = (32'(b) < 32'(eff_obj));
    end

    assign rd_word = rd_vld_reg ? rd_data_reg : '0;
    assign avail   = ~rd_word & obj_mask;

    // lowest set bit of the free map
    always_comb
    begin
        low_idx = '0;
        for (int b = OBJECTS_PER_CACHE - 1; b >= 0; b--)
        begin
            if (avail[b])
                low_idx = OBJ_W'(b);
        end
    end

    assign fc_idx     = CIDX_W'(req_cache_reg);
    assign fo_idx     = OBJ_W'(req_obj_reg);
    assign freed_word = rd_word & ~(word_t'(1) << fo_idx);
    assign flat_sum   = PROD_W'(res_obj_reg) + PROD_W'(eff_obj) * PROD_W'(res_cache_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic eligible;
        logic hit;
        logic last;
        logic take_abs;
        logic bad_free;

        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        have_abs_next   = have_abs_reg;
        abs_idx_next    = abs_idx_reg;
        list_len_next   = list_len_reg;
        present_next    = present_reg;
        req_type_next   = req_type_reg;
        req_cache_next  = req_cache_reg;
        req_obj_next    = req_obj_reg;
        res_status_next = res_status_reg;
        res_cache_next  = res_cache_reg;
        res_obj_next    = res_obj_reg;
        res_flat_next   = res_flat_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        rd_addr         = scan_idx_reg[CIDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = chk_idx_reg;
        wr_data         = rd_word;

        eligible = (LEN_W'(chk_idx_reg) < eff_fixed) || present_reg[chk_idx_reg];
        hit      = eligible && (avail != '0);
        last     = (LEN_W'(chk_idx_reg) == eff_len - LEN_W'(1));
        take_abs = !eligible && !have_abs_reg;
        bad_free = (32'(req_cache_reg) >= 32'(eff_len))
                || (32'(req_obj_reg) >= 32'(eff_obj))
                || ((32'(req_cache_reg) >= 32'(eff_fixed)) && !present_reg[fc_idx])
                || !rd_word[fo_idx];

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = CIDX_W'(in_data.free_cache);
                if (in_valid)
                begin
                    req_type_next  = in_data.req_type;
                    req_cache_next = in_data.free_cache;
                    req_obj_next   = in_data.free_object;
                    scan_idx_next  = '0;
                    have_abs_next  = 1'b0;
                    res_cache_next = '0;
                    res_obj_next   = '0;
                    res_flat_next  = '0;
                    state_next     = (in_data.req_type == REQ_FREE) ? S_FCHK : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, check the word read last cycle
                if (scan_idx_reg < eff_len)
                begin
                    scan_idx_next  = scan_idx_reg + LEN_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[CIDX_W-1:0];
                end
                if (chk_valid_reg)
                begin
                    if (hit)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = chk_idx_reg;
                        wr_data         = rd_word | (word_t'(1) << low_idx);
                        res_status_next = ST_OK;
                        res_cache_next  = chk_idx_reg;
                        res_obj_next    = low_idx;
                        chk_valid_next  = 1'b0;
                        state_next      = S_FLAT;
                    end
                    else
                    begin
                        if (take_abs)
                        begin
                            have_abs_next = 1'b1;
                            abs_idx_next  = chk_idx_reg;
                        end
                        if (last)
                        begin
                            chk_valid_next = 1'b0;
                            res_obj_next   = '0;
                            wr_data        = word_t'(1);
                            if (have_abs_reg || take_abs)
                            begin
                                // revive the first absent slot
                                wr_addr          = have_abs_reg ? abs_idx_reg : chk_idx_reg;
                                wr_en            = 1'b1;
                                present_next[wr_addr] = 1'b1;
                                res_status_next  = ST_OK;
                                res_cache_next   = wr_addr;
                                state_next       = S_FLAT;
                            end
                            else if (eff_len < eff_limit && 32'(eff_len) < MAX_CACHES)
                            begin
                                // append a cache at the end of the list
                                wr_addr          = eff_len[CIDX_W-1:0];
                                wr_en            = 1'b1;
                                present_next[wr_addr] = 1'b1;
                                list_len_next    = eff_len + LEN_W'(1);
                                res_status_next  = ST_OK;
                                res_cache_next   = wr_addr;
                                state_next       = S_FLAT;
                            end
                            else
                            begin
                                res_status_next = ST_NO_SPACE;
                                res_cache_next  = '0;
                                state_next      = S_DONE;
                            end
                        end
                    end
                end
            end

            S_FCHK:
            begin
                if (bad_free)
                    res_status_next = ST_BAD_FREE;
                else
                begin
                    res_status_next = ST_OK;
                    wr_en           = 1'b1;
                    wr_addr         = fc_idx;
                    wr_data         = freed_word;
                    // drop an emptied optional cache
                    if (32'(req_cache_reg) >= 32'(eff_fixed) && (freed_word & obj_mask) == '0)
                    begin
                        present_next[fc_idx] = 1'b0;
                        if (32'(req_cache_reg) == 32'(eff_len) - 1)
                            list_len_next = eff_len - LEN_W'(1);
                    end
                end
                state_next = S_DONE;
            end

            S_FLAT:
            begin
                res_flat_next = FLAT_FIELD_W'(flat_sum);
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.status     = res_status_reg;
                    out_data_next.got_cache  = CACHE_FIELD_W'(res_cache_reg);
                    out_data_next.got_object = OBJ_FIELD_W'(res_obj_reg);
                    out_data_next.flat_index = res_flat_reg;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // used-map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            used_mem[wr_addr] <= wr_data;
        rd_data_reg <= used_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                mem_vld_reg[wr_addr] <= 1'b1;
            rd_vld_reg <= mem_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            objects_in_cache_reg <= RST_OBJECTS_IN_CACHE;
            fixed_caches_reg     <= RST_FIXED_CACHES;
            cache_limit_reg      <= RST_CACHE_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OBJECTS_IN_CACHE: objects_in_cache_reg <= cfg_data;
                REG_FIXED_CACHES:     fixed_caches_reg     <= FIXED_REG_W'(cfg_data);
                REG_CACHE_LIMIT:      cache_limit_reg      <= LIMIT_REG_W'(cfg_data);
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            have_abs_reg  <= 1'b0;
            list_len_reg  <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            have_abs_reg  <= have_abs_next;
            list_len_reg  <= list_len_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        abs_idx_reg    <= abs_idx_next;
        req_type_reg   <= req_type_next;
        req_cache_reg  <= req_cache_next;
        req_obj_reg    <= req_obj_next;
        res_status_reg <= res_status_next;
        res_cache_reg  <= res_cache_next;
        res_obj_reg    <= res_obj_next;
        res_flat_reg   <= res_flat_next;
        out_data_reg   <= out_data_next;
    end

endmodule
`default_nettype wire

// ----- bench/soa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator result checker
// Watches the configuration port and both transfer channels of the allocator.
// It keeps its own copy of the used maps, the cache list and the registers.
// It predicts one result per accepted request and compares every result, field
// by field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module soa_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [soa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [soa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  soa_pkg::req_t                   in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  soa_pkg::rsp_t                   out_data,
    output int                              mismatches,
    output int                              pending_results
);
    import soa_pkg::*;

    localparam int NCACHE = DEF_MAX_CACHES;
    localparam int NOBJ   = DEF_OBJECTS_PER_CACHE;

    logic [63:0] used_bits [NCACHE];
    logic        present_bit [NCACHE];
    int          chain_len;
    int          objs_reg;
    int          fixed_reg;
    int          limit_reg;
    rsp_t        grant_q [$];

    initial mismatches = 0;

    function automatic int n_objects();
        int n;
        n = objs_reg;
        if (n < 1) n = 1;
        if (n > NOBJ) n = NOBJ;
        return n;
    endfunction

    function automatic int n_fixed();
        int n;
        n = fixed_reg;
        if (n < 1) n = 1;
        if (n > NCACHE) n = NCACHE;
        return n;
    endfunction

    function automatic int n_limit();
        return (limit_reg == 0 || limit_reg > NCACHE) ? NCACHE : limit_reg;
    endfunction

    // the list never reads shorter than the fixed caches
    function automatic int n_length();
        int n;
        n = chain_len;
        if (n < n_fixed()) n = n_fixed();
        if (n > NCACHE) n = NCACHE;
        return n;
    endfunction

    function automatic logic [63:0] obj_window();
        int n;
        n = n_objects();
        return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic int first_free(int c);
        logic [63:0] avail;
        avail = ~used_bits[c] & obj_window();
        for (int b = 0; b < 64; b++)
        begin
            if (avail[b]) return b;
        end
        return -1;
    endfunction

    function automatic rsp_t granted(int c, int o);
        rsp_t r;
        int   flat;
        flat         = o + n_objects() * c;
        r            = '0;
        r.status     = ST_OK;
        r.got_cache  = c[CACHE_FIELD_W-1:0];
        r.got_object = o[OBJ_FIELD_W-1:0];
        r.flat_index = flat[FLAT_FIELD_W-1:0];
        return r;
    endfunction

    function automatic rsp_t grant_object();
        int   fx;
        int   len;
        int   o;
        int   spare;
        int   pick;
        rsp_t r;
        fx    = n_fixed();
        len   = n_length();
        spare = -1;
        r     = '0;
        for (int c = 0; c < fx && c < len; c++)
        begin
            o = first_free(c);
            if (o >= 0)
            begin
                used_bits[c][o] = 1'b1;
                return granted(c, o);
            end
        end
        // optional caches: take a present one with room, remember the first hole
        for (int c = fx; c < len; c++)
        begin
            if (present_bit[c])
            begin
                o = first_free(c);
                if (o >= 0)
                begin
                    used_bits[c][o] = 1'b1;
                    return granted(c, o);
                end
            end
            else if (spare < 0)
            begin
                spare = c;
            end
        end
        if (spare >= 0)
        begin
            pick = spare;
        end
        else if (len < n_limit() && len < NCACHE)
        begin
            pick      = len;
            chain_len = len + 1;
        end
        else
        begin
            r.status = ST_NO_SPACE;
            return r;
        end
        present_bit[pick] = 1'b1;
        used_bits[pick]   = 64'd1;
        return granted(pick, 0);
    endfunction

    function automatic rsp_t release_object(int c, int o);
        int   fx;
        int   len;
        rsp_t r;
        fx = n_fixed();
        len = n_length();
        r  = '0;
        if (c >= len || o >= n_objects() || (c >= fx && !present_bit[c]) ||
            !used_bits[c][o])
        begin
            r.status = ST_BAD_FREE;
            return r;
        end
        used_bits[c][o] = 1'b0;
        // drop an emptied optional cache, shrink the list if it was the tail
        if (c >= fx && (used_bits[c] & obj_window()) == 64'd0)
        begin
            present_bit[c] = 1'b0;
            if (c == len - 1) chain_len = len - 1;
        end
        r.status = ST_OK;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        logic wrong;
        if (!rst_n)
        begin
            for (int i = 0; i < NCACHE; i++)
            begin
                used_bits[i]   = 64'd0;
                present_bit[i] = 1'b0;
            end
            chain_len = 0;
            objs_reg  = RST_OBJECTS_IN_CACHE;
            fixed_reg = RST_FIXED_CACHES;
            limit_reg = RST_CACHE_LIMIT;
            grant_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (grant_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result: status %0d cache %0d",
                                 $realtime, out_data.status, out_data.got_cache,
                                 " object %0d flat %0d",
                                 out_data.got_object, out_data.flat_index);
                    mismatches++;
                end
                else
                begin
                    want  = grant_q.pop_front();
                    wrong = (out_data.status !== want.status) ||
                            (out_data.got_cache !== want.got_cache) ||
                            (out_data.got_object !== want.got_object) ||
                            (out_data.flat_index !== want.flat_index);
                    if (wrong)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("[%0t] mismatch: expected status %0d cache %0d",
                                     $realtime, want.status, want.got_cache,
                                     " object %0d flat %0d",
                                     want.got_object, want.flat_index);
                            $display("    got status %0d cache %0d object %0d flat %0d",
                                     out_data.status, out_data.got_cache,
                                     out_data.got_object, out_data.flat_index);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_OBJECTS_IN_CACHE: objs_reg  = cfg_data[OBJ_CNT_REG_W-1:0];
                    REG_FIXED_CACHES:     fixed_reg = cfg_data[FIXED_REG_W-1:0];
                    REG_CACHE_LIMIT:      limit_reg = cfg_data[LIMIT_REG_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (in_data.req_type == REQ_ALLOC)
                    grant_q.push_back(grant_object());
                else
                    grant_q.push_back(release_object(in_data.free_cache, in_data.free_object));
            end
            pending_results <= grant_q.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator regression
// Drives allocate and free requests into the allocator under several register
// settings and idle patterns; the checker beside the block predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import soa_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 190;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    req_t                   in_data;
    logic                   out_valid;
    logic                   out_ready;
    rsp_t                   out_data;

    int mismatches;
    int pending_results;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct;
    int hold_asks;
    int hold_done = 0;
    int items_sent = 0;
    int n_grants = 0;
    int n_no_space = 0;
    int n_bad_free = 0;

    logic                                 kind_q [$];
    logic [CACHE_FIELD_W+OBJ_FIELD_W-1:0] live_objs [$];

    slab_object_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    soa_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asks)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Track granted objects so that most frees name a live one. Sample on the
    // falling edge ahead of the transfer edge, where the channel is already stable.
    always @(negedge clk)
    begin
        logic kind;
        if (rst_n === 1'b1 && out_valid && out_ready)
        begin
            kind = kind_q.pop_front();
            if (out_data.status == ST_NO_SPACE)
                n_no_space++;
            else if (out_data.status == ST_BAD_FREE)
                n_bad_free++;
            else if (kind == REQ_ALLOC)
            begin
                n_grants++;
                live_objs.push_back({out_data.got_cache, out_data.got_object});
            end
        end
    end

    function automatic req_t build_req(logic kind, int c, int o);
        req_t r;
        r.req_type    = kind;
        r.free_cache  = c[CACHE_FIELD_W-1:0];
        r.free_object = o[OBJ_FIELD_W-1:0];
        return r;
    endfunction

    // Mostly well-formed traffic: allocations and frees of live objects,
    // with a tail of random frees that are usually rejected.
    function automatic req_t next_request(int alloc_pct);
        req_t r;
        int   roll;
        int   k;
        roll = $urandom_range(99);
        r    = build_req(REQ_FREE, $urandom, $urandom);
        if (roll < alloc_pct)
        begin
            r.req_type = REQ_ALLOC;
        end
        else if (roll < 92 && live_objs.size() > 0)
        begin
            k = $urandom_range(live_objs.size() - 1);
            {r.free_cache, r.free_object} = live_objs[k];
            live_objs.delete(k);
        end
        return r;
    endfunction

    task automatic send(input req_t r);
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        kind_q.push_back(r.req_type);
        items_sent++;
    endtask

    task automatic idle_gap();
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold the sender until every result is back, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] objs,
                                input logic [CFG_DATA_W-1:0] fixed,
                                input logic [CFG_DATA_W-1:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OBJECTS_IN_CACHE;
        cfg_data  <= objs;
        @(posedge clk);
        cfg_index <= REG_FIXED_CACHES;
        cfg_data  <= fixed;
        @(posedge clk);
        cfg_index <= REG_CACHE_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] p_objs;
        logic [CFG_DATA_W-1:0] p_fixed;
        logic [CFG_DATA_W-1:0] p_limit;
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= REG_OBJECTS_IN_CACHE;
        cfg_data           <= '0;
        in_valid           <= 1'b0;
        in_data            <= '0;
        hold_asks          <= 0;
        receiver_stall_pct <= 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first objects, repeated free, a free out of range and one of an unused object
        send(build_req(REQ_ALLOC, 0, 0));
        send(build_req(REQ_ALLOC, 15, 63));
        send(build_req(REQ_FREE, 0, 1));
        send(build_req(REQ_FREE, 0, 1));
        send(build_req(REQ_FREE, 15, 63));
        send(build_req(REQ_FREE, 0, 63));

        // one object per cache: append, hit the limit, revive a hole, shrink
        drain();
        program_regs(7'd1, 7'd1, 7'd3);
        send(build_req(REQ_ALLOC, 0, 0));
        send(build_req(REQ_ALLOC, 0, 0));
        send(build_req(REQ_ALLOC, 0, 0));
        send(build_req(REQ_FREE, 1, 0));
        send(build_req(REQ_FREE, 0, 5));
        send(build_req(REQ_ALLOC, 0, 0));
        send(build_req(REQ_FREE, 2, 0));
        send(build_req(REQ_FREE, 2, 0));

        // limit below the fixed caches: nothing can be appended
        drain();
        program_regs(7'd2, 7'd4, 7'd2);
        repeat (7) send(build_req(REQ_ALLOC, 0, 0));

        // a formerly fixed cache turns optional and reads as absent
        drain();
        program_regs(7'd127, 7'd1, 7'd0);
        send(build_req(REQ_FREE, 3, 0));
        send(build_req(REQ_FREE, 1, 1));
        send(build_req(REQ_ALLOC, 0, 0));

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0: begin p_objs = 7'd64;  p_fixed = 7'd1;  p_limit = 7'd0;  end
                1: begin p_objs = 7'd1;   p_fixed = 7'd1;  p_limit = 7'd16; end
                2: begin p_objs = 7'd3;   p_fixed = 7'd4;  p_limit = 7'd7;  end
                3: begin p_objs = 7'd127; p_fixed = 7'd16; p_limit = 7'd0;  end
                4: begin p_objs = 7'd0;   p_fixed = 7'd0;  p_limit = 7'd3;  end
                5: begin p_objs = 7'd16;  p_fixed = 7'd31; p_limit = 7'd31; end
                6: begin p_objs = 7'd64;  p_fixed = 7'd3;  p_limit = 7'd2;  end
                default: begin p_objs = 7'd2; p_fixed = 7'd6; p_limit = 7'd10; end
            endcase
            program_regs(p_objs, p_fixed, p_limit);
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
                1: begin sender_idle_pct = 67; receiver_stall_pct <= 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct <= 67; end
                default: begin sender_idle_pct = 37; receiver_stall_pct <= 37; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // fill the block against a stalled receiver
                if (p == 2 && i == 100) hold_asks <= hold_asks + 1;
                if (p == 5 && i == 95) drain();
                idle_gap();
                // alternate filling and emptying bursts
                send(next_request(((i / 40) % 2 == 0) ? 75 : 25));
            end
        end
        drain();

        $display("Ran %0d requests over %0d register settings and four idle patterns",
                 items_sent, PHASES + 4);
        $display("Results: %0d grants, %0d out of space, %0d rejected frees",
                 n_grants, n_no_space, n_bad_free);
        if (mismatches == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
